// ===== hw/rtl/cim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cim_pkg;

    // Field ranges of the five schedule masks
    localparam int MIN_N  = 60;
    localparam int HOUR_N = 24;
    localparam int DAY_N  = 31;
    localparam int MON_N  = 12;
    localparam int WDAY_N = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MINUTE  = 3'd0,
        REG_HOUR    = 3'd1,
        REG_DAY     = 3'd2,
        REG_MONTH   = 3'd3,
        REG_WEEKDAY = 3'd4
    } cfg_reg_t;

    // Calendar constants
    localparam logic [3:0] MONTH_DEC  = 4'd12;
    localparam logic [4:0] LEN_LONG   = 5'd31;
    localparam logic [4:0] LEN_SHORT  = 5'd30;
    localparam logic [4:0] LEN_FEB    = 5'd28;
    localparam logic [4:0] LEN_FEB_LY = 5'd29;

    // Reciprocal of 25 scaled by 2^16, exact for every 12-bit year
    localparam logic [23:0] RECIP_25 = 24'd2622;
    localparam logic [12:0] CENT_25  = 13'd25;

    // Signed distance along one field, wide enough for every raw input
    typedef logic signed [8:0] dist_t;

    // One input word; the last field sits in the lowest bits
    typedef struct packed {
        logic [5:0]  end_minute;
        logic [4:0]  end_hour;
        logic [2:0]  end_weekday;
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [11:0] end_year;
        logic [5:0]  begin_minute;
        logic [4:0]  begin_hour;
        logic [2:0]  begin_weekday;
        logic [4:0]  begin_day;
        logic [3:0]  begin_month;
        logic [11:0] begin_year;
    } item_t;

    localparam int ITEM_W = $bits(item_t);
    localparam int IN_W   = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_W  = 8;

    // Zero-extend a small unsigned value into a distance
    function automatic dist_t dz(input logic [6:0] v);
        return dist_t'({2'b00, v});
    endfunction

    // Gregorian leap rule: by 4, not by 100 unless by 400
    function automatic logic is_leap(input logic [11:0] year);
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [12:0] back;
        logic        div25;
        prod  = {12'd0, year} * RECIP_25;
        quot  = prod[23:16];
        back  = 13'(quot) * CENT_25;
        div25 = (back == {1'b0, year});
        return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
    endfunction

    // Days in a month; any code outside the long and short months takes February
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12})
            len = LEN_LONG;
        else if (month inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = LEN_SHORT;
        else if (leap)
            len = LEN_FEB_LY;
        else
            len = LEN_FEB;
        return len;
    endfunction

    // Fold a start position that may lie up to one range past the top
    function automatic logic [6:0] fold(input logic [6:0] s, input logic [6:0] n);
        return (s >= n) ? 7'(s - n) : s;
    endfunction

    // Positions s, s+1, .. s+t modulo n; empty for negative t
    function automatic logic [63:0] wrap_span(input logic [6:0] n, input logic [6:0] s,
                                              input dist_t t);
        logic [63:0] m;
        logic [6:0]  idx;
        logic [6:0]  d;
        m = '0;
        for (int i = 0; i < 64; i++)
        begin
            idx = 7'(i);
            d   = (idx >= s) ? 7'(idx - s) : 7'(idx + n - s);
            if ((idx < n) && !t[8] && ({1'b0, d} <= t[7:0]))
                m[i] = 1'b1;
        end
        return m;
    endfunction

    // Bits a..b inclusive
    function automatic logic [63:0] range_mask(input logic [6:0] a, input logic [6:0] b);
        logic [63:0] m;
        logic [6:0]  idx;
        m = '0;
        for (int i = 0; i < 64; i++)
        begin
            idx = 7'(i);
            if ((idx >= a) && (idx <= b))
                m[i] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cron_interval_match_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cron schedule check over a time interval.
// s_* channel: one word per interval, begin and end as calendar fields.
// m_* channel: one word per interval: occurred and interval_error.
// cfg_* channel: writes minute, hour, day, month and weekday masks by index;
// an index past the weekday mask is ignored. cfg_ready is always high.
// m_tvalid rises once the word has passed the input register and then the result
// register: the word is registered, the active sets and mask intersections are
// built in one pass, and the flags land in the result register when it advances.
// Throughput is one word per cycle while m_tready stays high.
// When the receiver holds m_tready low, the result register holds and the
// input register still takes one more word; s_tready then drops until the
// result drains. Reset clears both valid flags and all masks to zero, so no
// schedule matches until the masks are written. The user must write masks only
// while no word is in flight; the block itself does not enforce this.
module cron_interval_match_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // begin_year, begin_month, begin_day, begin_weekday, begin_hour,
    // begin_minute, end_year, end_month, end_day, end_weekday, end_hour,
    // end_minute, zero pad
    input  wire logic [cim_pkg::IN_W-1:0]      s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // occurred, interval_error, zero pad
    output logic [cim_pkg::OUT_W-1:0]          m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cim_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Schedule masks
    logic [cim_pkg::MIN_N-1:0]  min_mask_reg,  min_mask_next;
    logic [cim_pkg::HOUR_N-1:0] hour_mask_reg, hour_mask_next;
    logic [cim_pkg::DAY_N-1:0]  day_mask_reg,  day_mask_next;
    logic [cim_pkg::MON_N-1:0]  mon_mask_reg,  mon_mask_next;
    logic [cim_pkg::WDAY_N-1:0] wday_mask_reg, wday_mask_next;

    // Pipeline registers
    cim_pkg::item_t item_reg;
    logic           in_valid_reg,  in_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic           occurred_reg,  occurred_next;
    logic           error_reg,     error_next;
    logic           adv_out;

    // Field views of the held word
    logic [11:0] by, ey;
    logic [3:0]  bm, em;
    logic [4:0]  bd, ed, bh, eh;
    logic [2:0]  bw, ew;
    logic [5:0]  bn, en;

    logic              err;
    logic [11:0]       ydiff;
    logic              y_far, y_wrap;
    logic              leap;
    logic [4:0]        top, top2;
    cim_pkg::dist_t    mdist, ddist, wdist, hdist, ndist;

    // Month set
    logic [6:0]        mon_s;
    cim_pkg::dist_t    mon_t;
    logic              mon_oor;
    logic [63:0]       mon_span;

    // Day walk
    logic [4:0]        s_day;
    cim_pkg::dist_t    t_eff;
    logic [6:0]        end1, upper, k2;
    logic              in_month, wrap_on;
    cim_pkg::dist_t    rem;
    logic [63:0]       walk_mask, head_mask, tail_mask, day_one;

    logic [63:0]       wday_span, hour_span, min_span;

    logic [cim_pkg::MIN_N-1:0]  a_min;
    logic [cim_pkg::HOUR_N-1:0] a_hour;
    logic [cim_pkg::DAY_N-1:0]  a_day;
    logic [cim_pkg::MON_N-1:0]  a_mon;
    logic [cim_pkg::WDAY_N-1:0] a_wday;

    // Accept a word whenever the input stage is empty or moves on
    assign adv_out   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || adv_out;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(cim_pkg::OUT_W - 2)'(0), error_reg, occurred_reg};

    // Configuration writes keep only the mask width
    always_comb
    begin
        min_mask_next  = min_mask_reg;
        hour_mask_next = hour_mask_reg;
        day_mask_next  = day_mask_reg;
        mon_mask_next  = mon_mask_reg;
        wday_mask_next = wday_mask_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cim_pkg::cfg_reg_t'(cfg_index))
                cim_pkg::REG_MINUTE:  min_mask_next  = cfg_data[cim_pkg::MIN_N-1:0];
                cim_pkg::REG_HOUR:    hour_mask_next = cfg_data[cim_pkg::HOUR_N-1:0];
                cim_pkg::REG_DAY:     day_mask_next  = cfg_data[cim_pkg::DAY_N-1:0];
                cim_pkg::REG_MONTH:   mon_mask_next  = cfg_data[cim_pkg::MON_N-1:0];
                cim_pkg::REG_WEEKDAY: wday_mask_next = cfg_data[cim_pkg::WDAY_N-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mask_reg  <= '0;
            hour_mask_reg <= '0;
            day_mask_reg  <= '0;
            mon_mask_reg  <= '0;
            wday_mask_reg <= '0;
        end
        else
        begin
            min_mask_reg  <= min_mask_next;
            hour_mask_reg <= hour_mask_next;
            day_mask_reg  <= day_mask_next;
            mon_mask_reg  <= mon_mask_next;
            wday_mask_reg <= wday_mask_next;
        end
    end

    // Advance the valid flags
    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = adv_out ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word and the result flags
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= cim_pkg::item_t'(s_tdata[cim_pkg::ITEM_W-1:0]);
        if (adv_out && in_valid_reg)
        begin
            occurred_reg <= occurred_next;
            error_reg    <= error_next;
        end
    end

    assign by = item_reg.begin_year;
    assign bm = item_reg.begin_month;
    assign bd = item_reg.begin_day;
    assign bw = item_reg.begin_weekday;
    assign bh = item_reg.begin_hour;
    assign bn = item_reg.begin_minute;
    assign ey = item_reg.end_year;
    assign em = item_reg.end_month;
    assign ed = item_reg.end_day;
    assign ew = item_reg.end_weekday;
    assign eh = item_reg.end_hour;
    assign en = item_reg.end_minute;

    // Order check, year distance and month lengths
    always_comb
    begin
        err    = {ey, em, ed, eh, en} < {by, bm, bd, bh, bn};
        ydiff  = ey - by;
        y_far  = (ydiff[11:1] != 11'd0);
        y_wrap = (ydiff == 12'd1);
        leap   = cim_pkg::is_leap(by);
        top    = cim_pkg::days_in(bm, leap);
        // the month after December is January of the next year
        top2   = (bm == cim_pkg::MONTH_DEC) ? cim_pkg::LEN_LONG
                                            : cim_pkg::days_in(4'(bm + 4'd1), leap);
    end

    // Distances along each field; each but the weekday also wraps when the coarser one moved by one
    always_comb
    begin
        if ((bm <= em) && !y_wrap)
            mdist = cim_pkg::dz(7'(em)) - cim_pkg::dz(7'(bm));
        else
            mdist = cim_pkg::dz(7'(cim_pkg::MON_N)) - cim_pkg::dz(7'(bm))
                  + cim_pkg::dz(7'(em));

        if ((bd <= ed) && (mdist != 9'sd1))
            ddist = cim_pkg::dz(7'(ed)) - cim_pkg::dz(7'(bd));
        else
            ddist = cim_pkg::dz(7'(top)) - cim_pkg::dz(7'(bd)) + cim_pkg::dz(7'(ed));

        if (bw <= ew)
            wdist = cim_pkg::dz(7'(ew)) - cim_pkg::dz(7'(bw));
        else
            wdist = cim_pkg::dz(7'(cim_pkg::WDAY_N)) - cim_pkg::dz(7'(bw))
                  + cim_pkg::dz(7'(ew));

        if ((bh <= eh) && (ddist != 9'sd1))
            hdist = cim_pkg::dz(7'(eh)) - cim_pkg::dz(7'(bh));
        else
            hdist = cim_pkg::dz(7'(cim_pkg::HOUR_N)) - cim_pkg::dz(7'(bh))
                  + cim_pkg::dz(7'(eh));

        if ((bn <= en) && (hdist != 9'sd1))
            ndist = cim_pkg::dz(7'(en)) - cim_pkg::dz(7'(bn));
        else
            ndist = cim_pkg::dz(7'(cim_pkg::MIN_N)) - cim_pkg::dz(7'(bn))
                  + cim_pkg::dz(7'(en));
    end

    // Month set; month zero starts just below January and drops that first step
    always_comb
    begin
        mon_oor = (bm == 4'd0) || (bm > cim_pkg::MONTH_DEC);
        if (bm == 4'd0)
        begin
            mon_s = 7'd0;
            mon_t = mdist - 9'sd1;
        end
        else
        begin
            mon_s = cim_pkg::fold(7'(bm - 4'd1), 7'(cim_pkg::MON_N));
            mon_t = mdist;
        end
        if ((mdist == 9'sd0) && mon_oor)
            mon_span = '0;
        else
            mon_span = cim_pkg::wrap_span(7'(cim_pkg::MON_N), mon_s, mon_t);
    end

    // Day walk: run to the month end, then restart at day one of the next month
    always_comb
    begin
        s_day    = (bd == 5'd0) ? 5'd1 : bd;
        t_eff    = (bd == 5'd0) ? (ddist - 9'sd1) : ddist;
        end1     = 7'(s_day) + t_eff[6:0];
        in_month = (s_day <= top);
        if (in_month)
            upper = (end1 < 7'(top)) ? end1 : 7'(top);
        else
            upper = (end1 < 7'(cim_pkg::DAY_N)) ? end1 : 7'(cim_pkg::DAY_N);
        rem     = cim_pkg::dz(end1) - cim_pkg::dz(7'(top));
        wrap_on = in_month && !rem[8] && (rem != 9'sd0);
        k2      = (rem[6:0] < 7'(top2)) ? rem[6:0] : 7'(top2);

        head_mask = cim_pkg::range_mask(7'(s_day) - 7'd1, upper - 7'd1);
        tail_mask = wrap_on ? cim_pkg::range_mask(7'd0, k2 - 7'd1) : '0;
        walk_mask = head_mask | tail_mask;
        day_one   = (bd == 5'd0) ? '0 : cim_pkg::range_mask(7'(bd) - 7'd1, 7'(bd) - 7'd1);
    end

    // Weekday, hour and minute spans
    always_comb
    begin
        if ((wdist == 9'sd0) && (7'(bw) >= 7'(cim_pkg::WDAY_N)))
            wday_span = '0;
        else
            wday_span = cim_pkg::wrap_span(7'(cim_pkg::WDAY_N),
                            cim_pkg::fold(7'(bw), 7'(cim_pkg::WDAY_N)), wdist);

        if ((hdist == 9'sd0) && (7'(bh) >= 7'(cim_pkg::HOUR_N)))
            hour_span = '0;
        else
            hour_span = cim_pkg::wrap_span(7'(cim_pkg::HOUR_N),
                            cim_pkg::fold(7'(bh), 7'(cim_pkg::HOUR_N)), hdist);

        if ((ndist == 9'sd0) && (7'(bn) >= 7'(cim_pkg::MIN_N)))
            min_span = '0;
        else
            min_span = cim_pkg::wrap_span(7'(cim_pkg::MIN_N),
                           cim_pkg::fold(7'(bn), 7'(cim_pkg::MIN_N)), ndist);
    end

    // Promote to full sets once a coarser field spans two or more units (weekdays: seven or more days)
    always_comb
    begin
        a_min  = '1;
        a_hour = '1;
        a_day  = '1;
        a_mon  = '1;
        a_wday = '1;
        if (!y_far)
        begin
            a_mon = mon_span[cim_pkg::MON_N-1:0];
            if (mdist < 9'sd2)
            begin
                if (ddist[8])
                    a_day = '0;
                else if (ddist == 9'sd0)
                    a_day = day_one[cim_pkg::DAY_N-1:0];
                else
                    a_day = walk_mask[cim_pkg::DAY_N-1:0];

                if (ddist < 9'sd7)
                    a_wday = wday_span[cim_pkg::WDAY_N-1:0];

                if (ddist < 9'sd2)
                begin
                    a_hour = hour_span[cim_pkg::HOUR_N-1:0];
                    if (hdist < 9'sd2)
                        a_min = min_span[cim_pkg::MIN_N-1:0];
                end
            end
        end
    end

    // Intersect each set with its mask
    always_comb
    begin
        error_next    = err;
        occurred_next = !err
                      && (|(a_min  & min_mask_reg))
                      && (|(a_hour & hour_mask_reg))
                      && (|(a_day  & day_mask_reg))
                      && (|(a_mon  & mon_mask_reg))
                      && (|(a_wday & wday_mask_reg));
    end

endmodule

`default_nettype wire
